// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define CHK_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// File: rtl/pps_pkg.sv
// Types and constants for the preemptive priority scheduler.
// No dependencies.
package pps_pkg;

   localparam int ARR_W   = 16;
   localparam int BUR_W   = 16;
   localparam int PRI_W   = 8;
   localparam int IDX_W   = 6;   // cell index, covers up to 64 cells
   localparam int CNT_W   = IDX_W + 1;
   localparam int JIDX_W  = 4;
   localparam int RES_W   = 21;
   localparam int TOT_W   = 25;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_LAUNCH,
      ST_SCAN,
      ST_CHARGE,
      ST_SETTLE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic             late;   // time beyond any arrival value
      logic [ARR_W-1:0] low;
   } time_view_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [ARR_W-1:0] arr;
      logic [BUR_W-1:0] bur;
      logic [PRI_W-1:0] pri;
   } load_cmd_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [BUR_W-1:0] span;
      logic [RES_W-1:0] fin;
   } charge_cmd_type;

   typedef struct packed {
      load_cmd_type   load;
      charge_cmd_type charge;
      logic           shift;
      logic           clear;
      logic           launch;
   } cell_ctl_type;

   typedef struct packed {
      logic             live;
      logic             have;
      logic [IDX_W-1:0] pick_idx;
      logic [PRI_W-1:0] pick_pri;
      logic [BUR_W-1:0] pick_rem;
      logic             have_next;
      logic [ARR_W-1:0] next_arr;
   } carry_type;

   typedef struct packed {
      logic [ARR_W-1:0] arr;
      logic [BUR_W-1:0] bur;
      logic [PRI_W-1:0] pri;
      logic [BUR_W-1:0] rem;
      logic [RES_W-1:0] comp;
      logic [RES_W-1:0] turn;
      logic [RES_W-1:0] waiting;
   } job_rec_type;

endpackage

// File: rtl/pps_if.sv
// Handshake channels for job beats in and result beats out.
// Depends on pps_pkg.
interface pps_req_if import pps_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ARR_W-1:0] arrival_time;
   logic [BUR_W-1:0] burst_time;
   logic [PRI_W-1:0] priority_req;
   logic             last;

   modport source (output valid, arrival_time, burst_time, priority_req, last,
                   input ready);
   modport sink (input valid, arrival_time, burst_time, priority_req, last,
                 output ready);
endinterface

interface pps_rsp_if import pps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [JIDX_W-1:0] job_index;
   logic [RES_W-1:0]  completion_time;
   logic [RES_W-1:0]  turnaround_time;
   logic [RES_W-1:0]  waiting_time;
   logic [TOT_W-1:0]  total_waiting;
   logic [TOT_W-1:0]  total_turnaround;
   logic              overflow;
   logic              last_result;

   modport source (output valid, job_index, completion_time, turnaround_time,
                   waiting_time, total_waiting, total_turnaround, overflow,
                   last_result, input ready);
   modport sink (input valid, job_index, completion_time, turnaround_time,
                 waiting_time, total_waiting, total_turnaround, overflow,
                 last_result, output ready);
endinterface

// File: rtl/preemptive_priority_scheduler.sv
// Top level: sequencer plus a row of MAX_JOBS job cells.
// Depends on pps_pkg, pps_if, pps_cell and pps_ctrl.
//
//   channel  port      dir  beat
//   jobs     req_bus   in   arrival_time, burst_time, priority_req, last
//   results  rsp_bus   out  job_index, times, totals, overflow, last_result
//
// Loading takes one cycle per job beat; the beat with last starts the schedule.
// Each schedule event (an arrival or a completion) costs one selection wave
// through the cell row; a wave that picks a job then charges its span in ST_CHARGE, ST_SETTLE.
// A set of n jobs has at most 2n + 1 events; results then drain one per cycle.
// Reset clears control state only; no clearing pass. A stalled result holds
// the drain, and req_bus is ready only between sets.
module preemptive_priority_scheduler import pps_pkg::*; #(
   parameter int MAX_JOBS = 16
) (
   input logic       clock,
   input logic       reset,
   pps_req_if.sink   req_bus,
   pps_rsp_if.source rsp_bus
);

   cell_ctl_type  ctl;
   time_view_type time_view;
   logic [CNT_W-1:0] job_cnt;
   carry_type     launch_carry;
   carry_type     carry_w [MAX_JOBS];
   job_rec_type   rec_w   [MAX_JOBS];

   always_comb begin
      launch_carry      = '0;
      launch_carry.live = ctl.launch;
   end

   pps_ctrl #(
      .MAX_JOBS (MAX_JOBS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .tail      (carry_w[MAX_JOBS-1]),
      .head      (rec_w[0]),
      .ctl       (ctl),
      .time_view (time_view),
      .job_cnt   (job_cnt)
   );

   for (genvar i = 0; i < MAX_JOBS; i++) begin : g_cell
      carry_type   prev_c;
      job_rec_type nbr_r;

      if (i == 0) begin : g_head
         assign prev_c = launch_carry;
      end else begin : g_body
         assign prev_c = carry_w[i-1];
      end

      if (i == MAX_JOBS - 1) begin : g_tail
         assign nbr_r = '0;
      end else begin : g_link
         assign nbr_r = rec_w[i+1];
      end

      pps_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_idx   (IDX_W'(i)),
         .job_cnt    (job_cnt),
         .time_view  (time_view),
         .ctl        (ctl),
         .prev_carry (prev_c),
         .nbr_rec    (nbr_r),
         .carry      (carry_w[i]),
         .rec        (rec_w[i])
      );
   end

endmodule

// File: rtl/pps_cell.sv
// One job cell: holds a job record, joins the selection wave and
// shifts its record toward the head during result drain. Depends on pps_pkg.
module pps_cell import pps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic [IDX_W-1:0] cell_idx,
   input  logic [CNT_W-1:0] job_cnt,
   input  time_view_type time_view,
   input  cell_ctl_type  ctl,
   input  carry_type     prev_carry,
   input  job_rec_type   nbr_rec,
   output carry_type     carry,
   output job_rec_type   rec
);

   job_rec_type rec_ff, rec_in;
   carry_type   carry_ff, carry_in;
   logic        done_ff, done_in;
   logic        active, arrived, hit;

   always_comb begin
      active  = {1'b0, cell_idx} < job_cnt;
      arrived = time_view.late || (rec_ff.arr <= time_view.low);

      carry_in = prev_carry;
      if (prev_carry.live && active && !done_ff) begin
         if (arrived) begin
            if (!prev_carry.have || (rec_ff.pri > prev_carry.pick_pri)) begin
               carry_in.have     = 1'b1;
               carry_in.pick_idx = cell_idx;
               carry_in.pick_pri = rec_ff.pri;
               carry_in.pick_rem = rec_ff.rem;
            end
         end else if (!prev_carry.have_next || (rec_ff.arr < prev_carry.next_arr)) begin
            carry_in.have_next = 1'b1;
            carry_in.next_arr  = rec_ff.arr;
         end
      end

      hit            = ctl.charge.en && (ctl.charge.idx == cell_idx);
      rec_in         = rec_ff;
      rec_in.waiting = rec_ff.turn - RES_W'(rec_ff.bur);
      done_in        = done_ff;
      if (ctl.shift) begin
         rec_in = nbr_rec;
      end else if (ctl.load.en && (ctl.load.idx == cell_idx)) begin
         rec_in.arr = ctl.load.arr;
         rec_in.bur = ctl.load.bur;
         rec_in.pri = ctl.load.pri;
         rec_in.rem = ctl.load.bur;
      end else if (hit) begin
         rec_in.rem = rec_ff.rem - ctl.charge.span;
         if (rec_ff.rem == ctl.charge.span) begin
            done_in     = 1'b1;
            rec_in.comp = ctl.charge.fin;
            rec_in.turn = ctl.charge.fin - RES_W'(rec_ff.arr);
         end
      end
      if (ctl.clear) begin
         done_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff <= '0;
      end else begin
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign carry = carry_ff;
   assign rec   = rec_ff;

endmodule

// File: rtl/pps_ctrl.sv
// Sequencer: job loading, schedule clock, span charging and result drain
// with the result register. Depends on pps_pkg and pps_if.
module pps_ctrl import pps_pkg::*; #(
   parameter int MAX_JOBS = 16
) (
   input  logic          clock,
   input  logic          reset,
   pps_req_if.sink       req,
   pps_rsp_if.source     rsp,
   input  carry_type     tail,
   input  job_rec_type   head,
   output cell_ctl_type  ctl,
   output time_view_type time_view,
   output logic [CNT_W-1:0] job_cnt
);

   localparam int NUM_W  = $clog2(MAX_JOBS + 1);
   localparam int TIME_W = $clog2((MAX_JOBS + 1) * (1 << ARR_W));

   state_type         state_ff, state_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  out_ff, out_in;
   logic              dropped_ff, dropped_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [BUR_W-1:0]  span_ff, span_in;
   charge_cmd_type    charge_ff, charge_in;
   logic [TOT_W-1:0]  tot_w_ff, tot_w_in;
   logic [TOT_W-1:0]  tot_t_ff, tot_t_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [JIDX_W-1:0] r_idx_ff, r_idx_in;
   logic [RES_W-1:0]  r_comp_ff, r_comp_in;
   logic [RES_W-1:0]  r_turn_ff, r_turn_in;
   logic [RES_W-1:0]  r_wait_ff, r_wait_in;
   logic [TOT_W-1:0]  r_totw_ff, r_totw_in;
   logic [TOT_W-1:0]  r_tott_ff, r_tott_in;
   logic              r_ovf_ff, r_ovf_in;
   logic              r_last_ff, r_last_in;

   logic              accept, room, rsp_room, out_last;
   logic [BUR_W-1:0]  bur_clamp, gap;
   logic [TIME_W-1:0] fin;
   logic [NUM_W-1:0]  out_nxt;
   logic [TOT_W-1:0]  w_sum, t_sum;

   assign req.ready = (state_ff == ST_LOAD);

   always_comb begin
      accept    = req.valid && req.ready;
      room      = num_ff < NUM_W'(MAX_JOBS);
      bur_clamp = (req.burst_time == '0) ? BUR_W'(1) : req.burst_time;
      gap       = tail.next_arr - time_ff[ARR_W-1:0];
      fin       = time_ff + TIME_W'(span_ff);
      rsp_room  = !rsp_valid_ff || rsp.ready;
      out_nxt   = out_ff + NUM_W'(1);
      out_last  = (out_nxt == num_ff);
      w_sum     = tot_w_ff + TOT_W'(head.waiting);
      t_sum     = tot_t_ff + TOT_W'(head.turn);

      state_in   = state_ff;
      num_in     = num_ff;
      out_in     = out_ff;
      dropped_in = dropped_ff;
      time_in    = time_ff;
      pick_in    = pick_ff;
      span_in    = span_ff;
      charge_in  = '0;
      tot_w_in   = tot_w_ff;
      tot_t_in   = tot_t_ff;

      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      r_idx_in     = r_idx_ff;
      r_comp_in    = r_comp_ff;
      r_turn_in    = r_turn_ff;
      r_wait_in    = r_wait_ff;
      r_totw_in    = r_totw_ff;
      r_tott_in    = r_tott_ff;
      r_ovf_in     = r_ovf_ff;
      r_last_in    = r_last_ff;

      ctl        = '0;
      ctl.charge = charge_ff;

      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (room) begin
                  ctl.load.en  = 1'b1;
                  ctl.load.idx = IDX_W'(num_ff);
                  ctl.load.arr = req.arrival_time;
                  ctl.load.bur = bur_clamp;
                  ctl.load.pri = req.priority_req;
                  num_in       = num_ff + NUM_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req.last) begin
                  state_in = ST_LAUNCH;
               end
            end
         end
         ST_LAUNCH: begin
            ctl.launch = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (tail.live) begin
               if (!tail.have && !tail.have_next) begin
                  state_in = ST_OUT;
               end else if (!tail.have) begin
                  time_in  = TIME_W'(tail.next_arr);
                  state_in = ST_LAUNCH;
               end else begin
                  pick_in  = tail.pick_idx;
                  span_in  = (tail.have_next && (gap < tail.pick_rem)) ? gap : tail.pick_rem;
                  state_in = ST_CHARGE;
               end
            end
         end
         ST_CHARGE: begin
            time_in        = fin;
            charge_in.en   = 1'b1;
            charge_in.idx  = pick_ff;
            charge_in.span = span_ff;
            charge_in.fin  = RES_W'(fin);
            state_in       = ST_SETTLE;
         end
         ST_SETTLE: begin
            state_in = ST_LAUNCH;
         end
         ST_OUT: begin
            if (rsp_room) begin
               rsp_valid_in = 1'b1;
               r_idx_in     = JIDX_W'(out_ff);
               r_comp_in    = head.comp;
               r_turn_in    = head.turn;
               r_wait_in    = head.waiting;
               r_ovf_in     = dropped_ff;
               r_last_in    = out_last;
               r_totw_in    = out_last ? w_sum : '0;
               r_tott_in    = out_last ? t_sum : '0;
               ctl.shift    = 1'b1;
               out_in       = out_nxt;
               tot_w_in     = w_sum;
               tot_t_in     = t_sum;
               if (out_last) begin
                  ctl.clear  = 1'b1;
                  num_in     = '0;
                  out_in     = '0;
                  dropped_in = 1'b0;
                  time_in    = '0;
                  tot_w_in   = '0;
                  tot_t_in   = '0;
                  state_in   = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff       <= '0;
         out_ff       <= '0;
         dropped_ff   <= 1'b0;
         time_ff      <= '0;
         charge_ff    <= '0;
         tot_w_ff     <= '0;
         tot_t_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_ff       <= num_in;
         out_ff       <= out_in;
         dropped_ff   <= dropped_in;
         time_ff      <= time_in;
         charge_ff    <= charge_in;
         tot_w_ff     <= tot_w_in;
         tot_t_ff     <= tot_t_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pick_ff   <= pick_in;
      span_ff   <= span_in;
      r_idx_ff  <= r_idx_in;
      r_comp_ff <= r_comp_in;
      r_turn_ff <= r_turn_in;
      r_wait_ff <= r_wait_in;
      r_totw_ff <= r_totw_in;
      r_tott_ff <= r_tott_in;
      r_ovf_ff  <= r_ovf_in;
      r_last_ff <= r_last_in;
   end

   assign time_view.late = |time_ff[TIME_W-1:ARR_W];
   assign time_view.low  = time_ff[ARR_W-1:0];
   assign job_cnt        = CNT_W'(num_ff);

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.job_index        = r_idx_ff;
   assign rsp.completion_time  = r_comp_ff;
   assign rsp.turnaround_time  = r_turn_ff;
   assign rsp.waiting_time     = r_wait_ff;
   assign rsp.total_waiting    = r_totw_ff;
   assign rsp.total_turnaround = r_tott_ff;
   assign rsp.overflow         = r_ovf_ff;
   assign rsp.last_result      = r_last_ff;

endmodule

// File: rtl/pps_checker.sv
// Port-level checks for the scheduler, bound to the top level.
// Depends on assert_macros.svh and pps_pkg.
`include "assert_macros.svh"

module pps_checker import pps_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_last_result,
   input logic [JIDX_W-1:0] rsp_job_index,
   input logic [RES_W-1:0] rsp_completion_time,
   input logic [TOT_W-1:0] rsp_total_waiting,
   input logic [TOT_W-1:0] rsp_total_turnaround
);

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `CHK_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_job_index) && $stable(rsp_completion_time))
   `CHK_SAME(a_no_load_in_drain, clock, reset, rsp_valid && !rsp_last_result, !req_ready)
   `CHK_SAME(a_totals_on_final, clock, reset, rsp_valid && !rsp_last_result, rsp_total_waiting == '0 && rsp_total_turnaround == '0)

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (
   .clock                (clock),
   .reset                (reset),
   .req_ready            (req_bus.ready),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_last_result      (rsp_bus.last_result),
   .rsp_job_index        (rsp_bus.job_index),
   .rsp_completion_time  (rsp_bus.completion_time),
   .rsp_total_waiting    (rsp_bus.total_waiting),
   .rsp_total_turnaround (rsp_bus.total_turnaround)
);

// File: tb/testbench.sv
// Self-checking testbench for preemptive_priority_scheduler: drives job sets,
// predicts each set's schedule in a scoreboard class and checks every result.
// Depends on pps_pkg, pps_if and the scheduler RTL.
module testbench;
   import pps_pkg::*;

   localparam int JOB_SLOTS   = 16;
   localparam int STALL_LIMIT = 8000;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      bit [ARR_W-1:0] arr;
      bit [BUR_W-1:0] bur;
      bit [PRI_W-1:0] pri;
   } job_entry_type;

   typedef struct {
      bit [JIDX_W-1:0] job_index;
      bit [RES_W-1:0]  completion_time;
      bit [RES_W-1:0]  turnaround_time;
      bit [RES_W-1:0]  waiting_time;
      bit [TOT_W-1:0]  total_waiting;
      bit [TOT_W-1:0]  total_turnaround;
      bit              overflow;
      bit              last_result;
   } result_beat_type;

   class schedule_checker;
      job_entry_type   held_jobs[$];
      bit              lost_job;
      result_beat_type expected_beats[$];
      int              beats_checked;
      int              mismatches;
      int              jobs_taken;
      int              sets_run;
      int              overflow_sets;

      function int pending();
         return expected_beats.size();
      endfunction

      function void take_job(bit [ARR_W-1:0] a, bit [BUR_W-1:0] b, bit [PRI_W-1:0] p,
                             bit l);
         job_entry_type j;
         jobs_taken++;
         j.arr = a;
         j.bur = (b == 0) ? BUR_W'(1) : b;
         j.pri = p;
         if (held_jobs.size() < JOB_SLOTS) held_jobs.push_back(j);
         else lost_job = 1;
         if (l) begin
            sets_run++;
            if (lost_job) overflow_sets++;
            play_schedule();
            held_jobs.delete();
            lost_job = 0;
         end
      endfunction

      // event-driven: the pick can only change at an arrival or a completion
      function void play_schedule();
         int unsigned     left[JOB_SLOTS];
         int unsigned     fin[JOB_SLOTS];
         bit              gone[JOB_SLOTS];
         int unsigned     now, span, next_arr, turn, wait_t, sum_w, sum_t;
         int              n, finished, best, i;
         bit              have, have_next;
         result_beat_type r;
         n = held_jobs.size();
         now = 0;
         finished = 0;
         sum_w = 0;
         sum_t = 0;
         for (i = 0; i < n; i++) begin
            left[i] = held_jobs[i].bur;
            gone[i] = 0;
         end
         while (finished < n) begin
            have = 0;
            have_next = 0;
            best = 0;
            next_arr = 0;
            for (i = 0; i < n; i++) begin
               if (gone[i]) continue;
               if (held_jobs[i].arr <= now) begin
                  if (!have || held_jobs[i].pri > held_jobs[best].pri) begin
                     have = 1;
                     best = i;
                  end
               end else if (!have_next || held_jobs[i].arr < next_arr) begin
                  have_next = 1;
                  next_arr = held_jobs[i].arr;
               end
            end
            if (!have) begin
               now = next_arr;
            end else begin
               span = left[best];
               if (have_next && next_arr - now < span) span = next_arr - now;
               now += span;
               left[best] -= span;
               if (left[best] == 0) begin
                  gone[best] = 1;
                  fin[best] = now;
                  finished++;
               end
            end
         end
         for (i = 0; i < n; i++) begin
            turn = fin[i] - held_jobs[i].arr;
            wait_t = turn - held_jobs[i].bur;
            sum_w += wait_t;
            sum_t += turn;
            r.job_index        = i[JIDX_W-1:0];
            r.completion_time  = fin[i][RES_W-1:0];
            r.turnaround_time  = turn[RES_W-1:0];
            r.waiting_time     = wait_t[RES_W-1:0];
            r.total_waiting    = '0;
            r.total_turnaround = '0;
            r.overflow         = lost_job;
            r.last_result      = (i == n - 1);
            if (i == n - 1) begin
               r.total_waiting    = sum_w[TOT_W-1:0];
               r.total_turnaround = sum_t[TOT_W-1:0];
            end
            expected_beats.push_back(r);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on result beat %0d, %s: expected %0d, got %0d",
                        beats_checked, name, want, seen);
         end
      endfunction

      function void check_beat(result_beat_type got);
         result_beat_type want;
         if (expected_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: job %0d completion %0d",
                        got.job_index, got.completion_time);
            return;
         end
         want = expected_beats.pop_front();
         compare_field("job_index", want.job_index, got.job_index);
         compare_field("completion_time", want.completion_time, got.completion_time);
         compare_field("turnaround_time", want.turnaround_time, got.turnaround_time);
         compare_field("waiting_time", want.waiting_time, got.waiting_time);
         compare_field("total_waiting", want.total_waiting, got.total_waiting);
         compare_field("total_turnaround", want.total_turnaround, got.total_turnaround);
         compare_field("overflow", want.overflow, got.overflow);
         compare_field("last_result", want.last_result, got.last_result);
         beats_checked++;
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   random_items;

   schedule_checker book = new;

   pps_req_if req_bus ();
   pps_rsp_if rsp_bus ();

   preemptive_priority_scheduler #(.MAX_JOBS(JOB_SLOTS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   task automatic send_job(input bit [ARR_W-1:0] a, input bit [BUR_W-1:0] b,
                           input bit [PRI_W-1:0] p, input bit l);
      while (!steady && $urandom_range(99) < 18) begin
         req_bus.valid = 0;
         @(negedge clock);
      end
      req_bus.valid        = 1;
      req_bus.arrival_time = a;
      req_bus.burst_time   = b;
      req_bus.priority_req = p;
      req_bus.last         = l;
      do @(posedge clock); while (!req_bus.ready);
      book.take_job(a, b, p, l);
      @(negedge clock);
   endtask

   task automatic send_random_set(input int count, input int flavor);
      bit [ARR_W-1:0] a;
      bit [BUR_W-1:0] b;
      bit [PRI_W-1:0] p;
      int             k;
      for (k = 0; k < count; k++) begin
         case (flavor)
            0: begin
               a = ARR_W'($urandom_range(40));
               b = BUR_W'($urandom_range(20));
               p = PRI_W'($urandom_range(3));
            end
            1: begin
               a = ARR_W'($urandom_range(3000));
               b = BUR_W'($urandom_range(400));
               p = PRI_W'($urandom_range(255));
            end
            default: begin
               a = ARR_W'($urandom);
               b = BUR_W'($urandom);
               p = PRI_W'($urandom);
            end
         endcase
         send_job(a, b, p, k == count - 1);
         random_items++;
      end
   endtask

   task automatic drain_results();
      while (book.pending() != 0) @(negedge clock);
   endtask

   initial begin
      int set_no, count, dice, k;
      reset = 1;
      steady = 0;
      random_items = 0;
      req_bus.valid = 0;
      req_bus.arrival_time = 0;
      req_bus.burst_time = 0;
      req_bus.priority_req = 0;
      req_bus.last = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // single job, zero burst
      send_job(16'h0000, 16'h0000, 8'h00, 1'b1);
      // field extremes, zero burst inside a set
      send_job(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
      send_job(16'h0000, 16'hFFFF, 8'h00, 1'b0);
      send_job(16'd100, 16'h0000, 8'hFF, 1'b0);
      send_job(16'hFFFF, 16'h0001, 8'h80, 1'b1);
      req_bus.valid = 0;
      drain_results();
      // seventeen jobs with equal priority: the marked one is dropped
      for (k = 0; k < 17; k++)
         send_job(ARR_W'(k * 3), BUR_W'($urandom_range(9)), 8'h40, k == 16);

      set_no = 0;
      while (random_items < 80) begin
         set_no++;
         steady = (set_no >= 3 && set_no <= 5);
         if (set_no == 7) begin
            req_bus.valid = 0;
            drain_results();
         end
         count = ($urandom_range(5) == 0) ? $urandom_range(20, 17) : $urandom_range(16, 1);
         dice = $urandom_range(9);
         send_random_set(count, (dice < 6) ? 0 : (dice < 9) ? 1 : 2);
      end
      steady = 0;
      req_bus.valid = 0;
      while (book.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("covered %0d job beats in %0d sets, %0d of them with dropped jobs",
               book.jobs_taken, book.sets_run, book.overflow_sets);
      $display("checked %0d result beats, %0d mismatches",
               book.beats_checked, book.mismatches);
      if (book.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // result side: random stalls plus one long hold-off to back up the input
   initial begin
      bit held;
      held = 0;
      rsp_bus.ready = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!held && book.beats_checked >= 25) begin
            held = 1;
            rsp_bus.ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_bus.ready = steady || ($urandom_range(99) >= 18);
      end
   end

   always @(posedge clock) begin : take_result
      result_beat_type beat;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         beat.job_index        = rsp_bus.job_index;
         beat.completion_time  = rsp_bus.completion_time;
         beat.turnaround_time  = rsp_bus.turnaround_time;
         beat.waiting_time     = rsp_bus.waiting_time;
         beat.total_waiting    = rsp_bus.total_waiting;
         beat.total_turnaround = rsp_bus.total_turnaround;
         beat.overflow         = rsp_bus.overflow;
         beat.last_result      = rsp_bus.last_result;
         book.check_beat(beat);
      end
   end

   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            stuck = 0;
         else
            stuck++;
      end
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               STALL_LIMIT, book.pending());
      $display("TB_ERROR");
      $finish;
   end

endmodule
